>>> rtl/fqp_pkg.sv
// Shared types and constants for the promotable waiting queue.
// Used by fqp_cell and fifo_queue_with_promote_top; no dependencies.
`timescale 1ns / 1ps

package fqp_pkg;

  // Field widths of the transactions.
  localparam int ID_W     = 16;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 4;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PROM = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOEFFECT = 2'd3;

  // Per-cycle command broadcast to every slot cell.
  typedef struct packed {
    logic enq;   // append at the first free slot
    logic deq;   // shift every slot one place towards the head
    logic swap;  // exchange the first match with its predecessor
  } cell_ctrl_t;

endpackage

>>> rtl/fqp_cell.sv
// One slot of the queue: holds an id and its valid bit, compares against
// the search id and moves data with its neighbours. Depends on fqp_pkg.
`timescale 1ns / 1ps

module fqp_cell
  import fqp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  cell_ctrl_t      ctrl_i,
  input  logic [ID_W-1:0] id_i,
  input  logic            prev_valid_i,
  input  logic [ID_W-1:0] prev_data_i,
  input  logic            next_valid_i,
  input  logic [ID_W-1:0] next_data_i,
  input  logic            seen_i,
  input  logic            next_first_i,
  output logic            seen_o,
  output logic            first_o,
  output logic            valid_o,
  output logic [ID_W-1:0] data_o,
  output logic            valid_nxt_o,
  output logic [ID_W-1:0] data_nxt_o
);

  logic            valid_r;
  logic [ID_W-1:0] data_r;
  logic            hit;

  // Compare stage; the seen chain marks the first match from the head.
  assign hit     = valid_r && (data_r == id_i);
  assign first_o = hit && !seen_i;
  assign seen_o  = seen_i || hit;

  // Next slot contents.
  always_comb begin
    valid_nxt_o = valid_r;
    data_nxt_o  = data_r;
    if (ctrl_i.deq) begin
      valid_nxt_o = next_valid_i;
      data_nxt_o  = next_data_i;
    end else if (ctrl_i.enq) begin
      if (!valid_r && prev_valid_i) begin
        valid_nxt_o = 1'b1;
        data_nxt_o  = id_i;
      end
    end else if (ctrl_i.swap) begin
      if (first_o) begin
        data_nxt_o = prev_data_i;
      end else if (next_first_i) begin
        data_nxt_o = next_data_i;
      end
    end
  end

  // Valid bit is control state; the id needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt_o;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt_o;
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

>>> rtl/fifo_queue_with_promote_top.sv
// Top level of the promotable waiting queue: a row of fqp_cell slots,
// the fill counter and the result register. Depends on fqp_pkg, fqp_cell.
`timescale 1ns / 1ps
//
//  Channel | Direction | tdata fields (lowest bit first)
//  --------+-----------+--------------------------------------------------
//  in_     | slave     | cmd[1:0], entry_id[17:2], zero pad to 24 bits
//  out_    | master    | status[1:0], count[5:2], head_valid[6],
//          |           | head_id[22:7], zero pad to 24 bits
//
// Each command is handled by the whole row: all slots compare in parallel,
// the first match is found by a ripple through the cell row, and every slot
// loads its new contents at the accepting edge. The result is loaded into
// the output register at that same edge; a new transaction is taken while
// it is empty or being read: one command per cycle while out_tready is high.
// Reset (rst_n low, synchronous) empties the queue and the output register.

module fifo_queue_with_promote_top
  import fqp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
)(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // cmd, entry_id
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // status, count, head_valid, head_id
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CMD_W-1:0] cmd;
  logic [ID_W-1:0]  entry_id;
  logic             accept;
  cell_ctrl_t       ctrl;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             full, empty, found, swap_go;

  logic                 valid_w     [QUEUE_DEPTH];
  logic [ID_W-1:0]      data_w      [QUEUE_DEPTH];
  logic                 valid_nxt_w [QUEUE_DEPTH];
  logic [ID_W-1:0]      data_nxt_w  [QUEUE_DEPTH];
  logic                 first_w     [QUEUE_DEPTH+1];
  logic                 seen_w      [QUEUE_DEPTH+1];

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [COUNT_W-1:0]   count_r;
  logic                 head_valid_r;
  logic [ID_W-1:0]      head_id_r, head_id_nxt;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  // Input unpacking and handshake.
  assign cmd       = in_tdata[CMD_W-1:0];
  assign entry_id  = in_tdata[CMD_W+ID_W-1:CMD_W];
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign found   = seen_w[QUEUE_DEPTH];
  assign swap_go = found && !first_w[0];

  // Command broadcast to the slot row.
  assign ctrl.enq  = accept && (cmd == CMD_ENQ) && !full;
  assign ctrl.deq  = accept && (cmd == CMD_DEQ) && !empty;
  assign ctrl.swap = accept && (cmd == CMD_PROM) && swap_go;

  assign seen_w[0]            = 1'b0;
  assign first_w[QUEUE_DEPTH] = 1'b0;

  // Row of slot cells, head at index zero.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic            pv, nv;
    logic [ID_W-1:0] pd, nd;

    if (i == 0) begin : g_head
      assign pv = 1'b1;
      assign pd = '0;
    end else begin : g_mid
      assign pv = valid_w[i-1];
      assign pd = data_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign nv = 1'b0;
      assign nd = '0;
    end else begin : g_body
      assign nv = valid_w[i+1];
      assign nd = data_w[i+1];
    end

    fqp_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl_i       (ctrl),
      .id_i         (entry_id),
      .prev_valid_i (pv),
      .prev_data_i  (pd),
      .next_valid_i (nv),
      .next_data_i  (nd),
      .seen_i       (seen_w[i]),
      .next_first_i (first_w[i+1]),
      .seen_o       (seen_w[i+1]),
      .first_o      (first_w[i]),
      .valid_o      (valid_w[i]),
      .data_o       (data_w[i]),
      .valid_nxt_o  (valid_nxt_w[i]),
      .data_nxt_o   (data_nxt_w[i])
    );
  end

  // Fill counter.
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.enq) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (ctrl.deq) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  // Status of the command being accepted.
  always_comb begin
    case (cmd)
      CMD_ENQ:  status_nxt = full ? ST_FULL : ST_DONE;
      CMD_DEQ:  status_nxt = empty ? ST_EMPTY : ST_DONE;
      CMD_PROM: status_nxt = empty ? ST_EMPTY : (swap_go ? ST_DONE : ST_NOEFFECT);
      default:  status_nxt = ST_NOEFFECT;
    endcase
  end

  assign head_id_nxt = valid_nxt_w[0] ? data_nxt_w[0] : '0;
  assign cnt_ext     = {{COUNT_W{1'b0}}, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= status_nxt;
      count_r      <= cnt_ext[COUNT_W-1:0];
      head_valid_r <= valid_nxt_w[0];
      head_id_r    <= head_id_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {
    {(OUT_TDATA_W - STATUS_W - COUNT_W - 1 - ID_W){1'b0}},
    head_id_r, head_valid_r, count_r, status_r
  };

endmodule

>>> tb/sv/tb_fifo_queue_with_promote_top.sv
// Self-checking testbench for fifo_queue_with_promote_top: directed and random
// enqueue, dequeue and promote transactions against a behavioural queue model.
// Depends on fqp_pkg and the RTL of fifo_queue_with_promote_top.
`timescale 1ns / 1ps

module tb_fifo_queue_with_promote_top;
  import fqp_pkg::*;

  localparam int QUEUE_DEPTH    = 8;
  localparam int CLK_HALF       = 5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1825;
  localparam int MAX_REPORTS    = 50;

  // The package names no code for the spare command value.
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  // One decoded result transaction.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                head_valid;
    logic [ID_W-1:0]     head_id;
  } queue_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Model of the queue contents, head first, and the results still owed.
  logic [ID_W-1:0] held_ids[$];
  queue_result_t   pending_results[$];
  queue_result_t   oldest_result;

  int  mismatch_count = 0;
  int  stall_left     = 0;
  int  idle_cycles    = 0;
  bit  send_gaps_on   = 1'b1;
  bit  stalls_on      = 1'b1;

  fifo_queue_with_promote_top #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock generation.
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Length of an idle stretch: mostly short, now and then long.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 8);
    else return $urandom_range(12, 30);
  endfunction

  // Applies one command to the model queue and returns the result it owes.
  function automatic queue_result_t predict_queue_cmd(input logic [CMD_W-1:0] cmd,
                                                      input logic [ID_W-1:0] id);
    queue_result_t res;
    int            pos;
    logic [ID_W-1:0] tmp;
    res.status = ST_NOEFFECT;
    pos = -1;
    case (cmd)
      CMD_ENQ: begin
        if (held_ids.size() >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          held_ids.push_back(id);
          res.status = ST_DONE;
        end
      end
      CMD_DEQ: begin
        if (held_ids.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          void'(held_ids.pop_front());
          res.status = ST_DONE;
        end
      end
      CMD_PROM: begin
        if (held_ids.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // Only the first match from the head moves.
          for (int i = 0; i < held_ids.size(); i++) begin
            if (pos < 0 && held_ids[i] == id) pos = i;
          end
          if (pos > 0) begin
            tmp               = held_ids[pos];
            held_ids[pos]     = held_ids[pos - 1];
            held_ids[pos - 1] = tmp;
            res.status        = ST_DONE;
          end
        end
      end
      default: res.status = ST_NOEFFECT;
    endcase
    res.count      = COUNT_W'(held_ids.size());
    res.head_valid = (held_ids.size() > 0);
    res.head_id    = (held_ids.size() > 0) ? held_ids[0] : '0;
    return res;
  endfunction

  // Counts one mismatch and prints a line for it, up to MAX_REPORTS lines.
  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t ns: mismatch in %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // Sends one command transaction, at times after a random gap, and records its predicted result.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
    int gap;
    gap = 0;
    if (send_gaps_on && $urandom_range(0, 99) < 40) gap = idle_length();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - CMD_W - ID_W){1'b0}}, id, cmd};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_queue_cmd(cmd, id));
  endtask

  // Result side back-pressure.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 99) < 20) begin
      out_tready <= 1'b0;
      stall_left <= idle_length() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare every result transaction with the oldest outstanding prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result transaction", int'(out_tdata), 0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_tdata[1:0] !== oldest_result.status)
          report_mismatch("status", int'(out_tdata[1:0]), int'(oldest_result.status));
        if (out_tdata[5:2] !== oldest_result.count)
          report_mismatch("count", int'(out_tdata[5:2]), int'(oldest_result.count));
        if (out_tdata[6] !== oldest_result.head_valid)
          report_mismatch("head_valid", int'(out_tdata[6]),
                          int'(oldest_result.head_valid));
        if (out_tdata[22:7] !== oldest_result.head_id)
          report_mismatch("head_id", int'(out_tdata[22:7]), int'(oldest_result.head_id));
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Commands on an empty queue, including the spare command code.
  task automatic test_empty_queue();
    send_cmd(CMD_DEQ, 16'h0000);
    send_cmd(CMD_PROM, 16'hFFFF);
    send_cmd(CMD_NONE, 16'hFFFF);
  endtask

  // Fill to the top with extreme and duplicate ids, then overflow once.
  task automatic test_fill_to_full();
    send_cmd(CMD_ENQ, 16'hFFFF);
    send_cmd(CMD_ENQ, 16'h0000);
    send_cmd(CMD_ENQ, 16'h1234);
    send_cmd(CMD_ENQ, 16'h0000);
    send_cmd(CMD_ENQ, 16'hAAAA);
    send_cmd(CMD_ENQ, 16'h5555);
    send_cmd(CMD_ENQ, 16'h8001);
    send_cmd(CMD_ENQ, 16'h7FFE);
    send_cmd(CMD_ENQ, 16'h4321);
  endtask

  // Promote at the head, a duplicate, an absent id and the tail, then the spare command.
  task automatic test_promote_cases();
    send_cmd(CMD_PROM, 16'hFFFF);
    send_cmd(CMD_PROM, 16'h0000);
    send_cmd(CMD_PROM, 16'hBEEF);
    send_cmd(CMD_PROM, 16'h7FFE);
    send_cmd(CMD_NONE, 16'h0000);
  endtask

  // Empty the queue completely.
  task automatic test_drain();
    repeat (QUEUE_DEPTH) send_cmd(CMD_DEQ, 16'hFFFF);
  endtask

  // Random traffic in segments that lean towards filling, balance or draining.
  task automatic test_random_traffic(input int n_items);
    logic [ID_W-1:0]  id_pool[8];
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    int               lean;
    int               enq_pct;
    int               deq_pct;
    int               r;
    foreach (id_pool[i]) id_pool[i] = ID_W'($urandom_range(0, 16'hFFFF));
    lean = 1;
    for (int k = 0; k < n_items; k++) begin
      if (k % 60 == 0) begin
        lean         = $urandom_range(0, 2);
        send_gaps_on = ($urandom_range(0, 3) != 0);
        stalls_on    = ($urandom_range(0, 3) != 0);
        id_pool[$urandom_range(0, 7)] = ID_W'($urandom_range(0, 16'hFFFF));
      end
      case (lean)
        0:       begin enq_pct = 55; deq_pct = 15; end
        1:       begin enq_pct = 35; deq_pct = 30; end
        default: begin enq_pct = 20; deq_pct = 45; end
      endcase
      r = $urandom_range(0, 99);
      if (r < 3) cmd = CMD_NONE;
      else if (r < 3 + enq_pct) cmd = CMD_ENQ;
      else if (r < 3 + enq_pct + deq_pct) cmd = CMD_DEQ;
      else cmd = CMD_PROM;
      // Mostly reuse ids so that duplicates and promote hits are common.
      if (cmd == CMD_PROM && held_ids.size() > 0 && $urandom_range(0, 99) < 65)
        id = held_ids[$urandom_range(0, held_ids.size() - 1)];
      else if ($urandom_range(0, 99) < 60)
        id = id_pool[$urandom_range(0, 7)];
      else
        id = ID_W'($urandom_range(0, 16'hFFFF));
      send_cmd(cmd, id);
    end
  endtask

  // Lower valid and wait for every outstanding result, then a short tail.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    stalls_on = 1'b1;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Test sequence.
  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_fill_to_full();
    test_promote_cases();
    test_drain();
    test_random_traffic(RANDOM_ITEMS);
    wait_drained();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/fqp_pkg.sv
rtl/fqp_cell.sv
rtl/fifo_queue_with_promote_top.sv
tb/sv/tb_fifo_queue_with_promote_top.sv
